// File: rtl/rasl_pkg.sv
package rasl_pkg;

    typedef enum logic [2:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5,
        CFG_PAR_THR   = 3'd6
    } rasl_cfg_idx_t;

    localparam int NUM_AXES = 3;
    localparam int THR_WIDTH = 16;
    localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd1;

    typedef struct packed {
        logic par;
        logic pmiss;
        logic lo_neg;
        logic hi_neg;
        logic d_neg;
    } rasl_axis_flags_t;

endpackage

// File: rtl/rasl_prep.sv
module rasl_prep #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              ce,
    input  logic signed [COORD_WIDTH-1:0]     origin,
    input  logic signed [COORD_WIDTH-1:0]     dir,
    input  logic signed [COORD_WIDTH-1:0]     lo,
    input  logic signed [COORD_WIDTH-1:0]     hi,
    input  logic [rasl_pkg::THR_WIDTH-1:0]    thr,
    output rasl_pkg::rasl_axis_flags_t        flags_reg,
    output logic [COORD_WIDTH:0]              lo_mag_reg,
    output logic [COORD_WIDTH:0]              hi_mag_reg,
    output logic [COORD_WIDTH-1:0]            dmag_reg
);
    import rasl_pkg::*;

    localparam int W = COORD_WIDTH;

    logic signed [W:0]  nlo, nhi;
    logic [W-1:0]       dmag, thr_ext;
    rasl_axis_flags_t   flags_next;

    always_comb begin
        nlo = {lo[W-1], lo} - {origin[W-1], origin};
        nhi = {hi[W-1], hi} - {origin[W-1], origin};
        dmag = dir[W-1] ? (~dir + 1'b1) : dir;
        thr_ext = {{(W-THR_WIDTH){1'b0}}, thr};
        flags_next.par = (dir == '0) || (dmag < thr_ext);
        flags_next.pmiss = flags_next.par && ((origin < lo) || (hi < origin));
        flags_next.lo_neg = nlo[W];
        flags_next.hi_neg = nhi[W];
        flags_next.d_neg = dir[W-1];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            flags_reg <= flags_next;
            lo_mag_reg <= nlo[W] ? (~nlo + 1'b1) : nlo;
            hi_mag_reg <= nhi[W] ? (~nhi + 1'b1) : nhi;
            dmag_reg <= dmag;
        end
    end
endmodule

// File: rtl/rasl_div.sv
module rasl_div #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  ce,
    input  logic [COORD_WIDTH:0]                  nmag,
    input  logic [COORD_WIDTH-1:0]                dmag,
    output logic [COORD_WIDTH+FRAC_BITS:0]        quot
);
    localparam int W = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;

    logic [W-1:0]  r_reg [NW];
    logic [NW-1:0] q_reg [NW];
    logic [NW-1:0] n_reg [NW];
    logic [W-1:0]  d_reg [NW];

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [W-1:0]  r_in;
            logic [NW-1:0] q_in;
            logic [NW-1:0] n_in;
            logic [W-1:0]  d_in;
            logic [W:0]    rs;
            logic [W:0]    rn;
            logic          ge;

            if (k == 0) begin : g_first
                assign r_in = '0;
                assign q_in = '0;
                assign n_in = {nmag, {FRAC_BITS{1'b0}}};
                assign d_in = dmag;
            end else begin : g_next
                assign r_in = r_reg[k-1];
                assign q_in = q_reg[k-1];
                assign n_in = n_reg[k-1];
                assign d_in = d_reg[k-1];
            end

            always_comb begin
                rs = {r_in, n_in[NW-1]};
                ge = rs >= {1'b0, d_in};
                rn = ge ? (rs - {1'b0, d_in}) : rs;
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    r_reg[k] <= rn[W-1:0];
                    q_reg[k] <= {q_in[NW-2:0], ge};
                    n_reg[k] <= {n_in[NW-2:0], 1'b0};
                    d_reg[k] <= d_in;
                end
            end
        end
    endgenerate

    assign quot = q_reg[NW-1];
endmodule

// File: rtl/rasl_post.sv
module rasl_post #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                               aclk,
    input  logic                               ce,
    input  logic [COORD_WIDTH+FRAC_BITS:0]     q_lo,
    input  logic [COORD_WIDTH+FRAC_BITS:0]     q_hi,
    input  rasl_pkg::rasl_axis_flags_t         flags,
    output logic signed [COORD_WIDTH-1:0]      tmin_reg,
    output logic signed [COORD_WIDTH-1:0]      tmax_reg
);
    import rasl_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;
    localparam logic [W-1:0] PMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic [W-1:0] sat(input logic [NW-1:0] q, input logic neg);
        logic big;
        logic over;
        big = q[NW-1:W-1] != '0;
        over = (q[NW-1:W] != '0) || (q[W-1] && (q[W-2:0] != '0));
        if (q == '0) begin
            sat = '0;
        end else if (!neg) begin
            sat = big ? PMAX : q[W-1:0];
        end else begin
            sat = over ? NMIN : (~q[W-1:0] + 1'b1);
        end
    endfunction

    logic signed [W-1:0] t0_reg, t1_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            t0_reg <= sat(q_lo, flags.lo_neg ^ flags.d_neg);
            t1_reg <= sat(q_hi, flags.hi_neg ^ flags.d_neg);
            tmin_reg <= (t1_reg < t0_reg) ? t1_reg : t0_reg;
            tmax_reg <= (t1_reg < t0_reg) ? t0_reg : t1_reg;
        end
    end
endmodule

// File: rtl/ray_aabb_slab_test_core.sv
// Channel  Direction  tdata (low bit up)                               tuser
// s_axis   in         origin_x/y/z, dir_x/y/z, max_length              length_limited
// m_axis   out        hit_distance                                     hit
// cfg      in         write port, cfg_addr selects the register        -
//
// One ray enters every cycle while m_axis is not stalled.
// The restoring divider produces one quotient bit per stage.
// Reset clears valid bits and loads the reset box and threshold.
// A stall on m_axis holds every stage; s_axis_tready follows it.
module ray_aabb_slab_test_core #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_addr,
    input  logic [COORD_WIDTH-1:0]              cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_length
    input  logic [((7*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    // length_limited
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // hit_distance
    output logic [((COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // hit
    output logic [0:0]                          m_axis_tuser
);
    import rasl_pkg::*;

    localparam int W = COORD_WIDTH;
    localparam int NW = COORD_WIDTH + 1 + FRAC_BITS;
    localparam int OUT_W = ((COORD_WIDTH+7)/8)*8;
    localparam logic [W-1:0] PMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] NMIN = {1'b1, {(W-1){1'b0}}};

    logic [W-1:0]           box_min_reg [NUM_AXES];
    logic [W-1:0]           box_max_reg [NUM_AXES];
    logic [THR_WIDTH-1:0]   thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                box_min_reg[i] <= '0;
                box_max_reg[i] <= '0;
            end
            thr_reg <= THR_RESET;
        end else if (cfg_we) begin
            case (rasl_cfg_idx_t'(cfg_addr))
                CFG_BOX_MIN_X: box_min_reg[0] <= cfg_wdata;
                CFG_BOX_MIN_Y: box_min_reg[1] <= cfg_wdata;
                CFG_BOX_MIN_Z: box_min_reg[2] <= cfg_wdata;
                CFG_BOX_MAX_X: box_max_reg[0] <= cfg_wdata;
                CFG_BOX_MAX_Y: box_max_reg[1] <= cfg_wdata;
                CFG_BOX_MAX_Z: box_max_reg[2] <= cfg_wdata;
                CFG_PAR_THR:   thr_reg <= cfg_wdata[THR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    logic ce;
    logic m_valid_reg;
    assign ce = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    logic                   p_valid_reg, p_ll_reg;
    logic [W-1:0]           p_ml_reg;
    rasl_axis_flags_t       p_flags [NUM_AXES];
    logic [W:0]             p_lo_mag [NUM_AXES];
    logic [W:0]             p_hi_mag [NUM_AXES];
    logic [W-1:0]           p_dmag [NUM_AXES];
    logic [NW-1:0]          q_lo [NUM_AXES];
    logic [NW-1:0]          q_hi [NUM_AXES];
    logic signed [W-1:0]    tmin [NUM_AXES];
    logic signed [W-1:0]    tmax [NUM_AXES];

    logic               dl_valid_reg [NW];
    logic               dl_ll_reg [NW];
    logic [W-1:0]       dl_ml_reg [NW];
    rasl_axis_flags_t   dl_flags_reg [NW][NUM_AXES];

    genvar a;
    generate
        for (a = 0; a < NUM_AXES; a++) begin : g_axis
            rasl_prep #(.COORD_WIDTH(W)) u_prep (
                .aclk       (aclk),
                .ce         (ce),
                .origin     (s_axis_tdata[a*W +: W]),
                .dir        (s_axis_tdata[(3+a)*W +: W]),
                .lo         (box_min_reg[a]),
                .hi         (box_max_reg[a]),
                .thr        (thr_reg),
                .flags_reg  (p_flags[a]),
                .lo_mag_reg (p_lo_mag[a]),
                .hi_mag_reg (p_hi_mag[a]),
                .dmag_reg   (p_dmag[a])
            );
            rasl_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_lo (
                .aclk (aclk),
                .ce   (ce),
                .nmag (p_lo_mag[a]),
                .dmag (p_dmag[a]),
                .quot (q_lo[a])
            );
            rasl_div #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_hi (
                .aclk (aclk),
                .ce   (ce),
                .nmag (p_hi_mag[a]),
                .dmag (p_dmag[a]),
                .quot (q_hi[a])
            );
            rasl_post #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_post (
                .aclk     (aclk),
                .ce       (ce),
                .q_lo     (q_lo[a]),
                .q_hi     (q_hi[a]),
                .flags    (dl_flags_reg[NW-1][a]),
                .tmin_reg (tmin[a]),
                .tmax_reg (tmax[a])
            );
        end
    endgenerate

    logic               a_valid_reg, a_ll_reg;
    logic [W-1:0]       a_ml_reg;
    rasl_axis_flags_t   a_flags_reg [NUM_AXES];
    logic               b_valid_reg, b_ll_reg;
    logic [W-1:0]       b_ml_reg;
    rasl_axis_flags_t   b_flags_reg [NUM_AXES];
    logic               c_valid_reg, c_ll_reg, c_pmiss_reg;
    logic [W-1:0]       c_ml_reg;
    logic signed [W-1:0] c_near_reg, c_far_reg;
    logic signed [W-1:0] near_next, far_next;
    logic               pmiss_next;
    logic               hit_next;
    logic signed [W-1:0] dist_next;
    logic               m_hit_reg;
    logic [W-1:0]       m_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            for (int i = 0; i < NW; i++) dl_valid_reg[i] <= 1'b0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            p_valid_reg <= s_axis_tvalid;
            dl_valid_reg[0] <= p_valid_reg;
            for (int i = 1; i < NW; i++) dl_valid_reg[i] <= dl_valid_reg[i-1];
            a_valid_reg <= dl_valid_reg[NW-1];
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            p_ll_reg <= s_axis_tuser[0];
            p_ml_reg <= s_axis_tdata[6*W +: W];
            dl_ll_reg[0] <= p_ll_reg;
            dl_ml_reg[0] <= p_ml_reg;
            dl_flags_reg[0] <= p_flags;
            for (int i = 1; i < NW; i++) begin
                dl_ll_reg[i] <= dl_ll_reg[i-1];
                dl_ml_reg[i] <= dl_ml_reg[i-1];
                dl_flags_reg[i] <= dl_flags_reg[i-1];
            end
            a_ll_reg <= dl_ll_reg[NW-1];
            a_ml_reg <= dl_ml_reg[NW-1];
            a_flags_reg <= dl_flags_reg[NW-1];
            b_ll_reg <= a_ll_reg;
            b_ml_reg <= a_ml_reg;
            b_flags_reg <= a_flags_reg;
            c_ll_reg <= b_ll_reg;
            c_ml_reg <= b_ml_reg;
            c_pmiss_reg <= pmiss_next;
            c_near_reg <= near_next;
            c_far_reg <= far_next;
            m_hit_reg <= hit_next;
            m_dist_reg <= hit_next ? dist_next : '0;
        end
    end

    always_comb begin
        near_next = NMIN;
        far_next = PMAX;
        pmiss_next = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            pmiss_next = pmiss_next | b_flags_reg[i].pmiss;
            if (!b_flags_reg[i].par && (tmin[i] > near_next)) near_next = tmin[i];
            if (!b_flags_reg[i].par && (tmax[i] < far_next)) far_next = tmax[i];
        end
    end

    always_comb begin
        dist_next = (c_near_reg > 0) ? c_near_reg : c_far_reg;
        hit_next = !c_pmiss_reg && !(c_far_reg < c_near_reg) && !c_far_reg[W-1]
                   && !(c_ll_reg && ($signed(c_ml_reg) < dist_next));
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser = m_hit_reg;
    assign m_axis_tdata = {{(OUT_W-W){1'b0}}, m_dist_reg};
endmodule

// File: rtl/rasl_checker.sv
module rasl_checker #(
    parameter int COORD_WIDTH = 32
) (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_axis_tready,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((COORD_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    input logic [0:0]                           m_axis_tuser
);
    a_no_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("miss with nonzero distance");

    a_hit_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tdata[COORD_WIDTH-1])
        else $error("hit with negative distance");
endmodule

bind ray_aabb_slab_test_core rasl_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rasl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import rasl_pkg::*;

    localparam int CW = 32;
    localparam int FB = 16;
    localparam int LATENCY = CW + FB + 6;
    localparam int IDLE_LIMIT = 5000;
    localparam longint PMAXV = 64'sd2147483647;
    localparam longint NMINV = -64'sd2147483648;

    typedef struct {
        logic signed [CW-1:0] origin[3];
        logic signed [CW-1:0] dir[3];
        logic signed [CW-1:0] max_length;
        logic                 length_limited;
    } ray_t;

    typedef struct {
        logic          hit;
        logic [CW-1:0] hit_distance;
    } hit_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            cfg_we = 1'b0;
    logic [2:0]      cfg_addr = '0;
    logic [CW-1:0]   cfg_wdata = '0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [223:0]    s_axis_tdata = '0;  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, max_length
    logic [0:0]      s_axis_tuser = '0;  // length_limited
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [31:0]     m_axis_tdata;       // hit_distance
    logic [0:0]      m_axis_tuser;       // hit

    logic signed [CW-1:0] box_lo[3];
    logic signed [CW-1:0] box_hi[3];
    logic [THR_WIDTH-1:0] par_thr;

    hit_t pending_hits[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   sink_stall = 0;
    bit   calm = 1'b0;

    ray_aabb_slab_test_core #(.COORD_WIDTH(CW), .FRAC_BITS(FB)) uut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint slab_dist(longint bound, longint o, longint d);
        longint q;
        q = ((bound - o) <<< FB) / d;
        if (q > PMAXV) return PMAXV;
        if (q < NMINV) return NMINV;
        return q;
    endfunction

    function automatic hit_t trace_ray(ray_t r);
        hit_t   res;
        longint near_t, far_t, o, d, dmag, t0, t1, tmp, hit_dist;
        near_t = NMINV;
        far_t  = PMAXV;
        res.hit = 1'b0;
        res.hit_distance = '0;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            o = r.origin[ax];
            d = r.dir[ax];
            dmag = (d < 0) ? -d : d;
            if (d == 0 || dmag < longint'(par_thr)) begin
                if (o < longint'(box_lo[ax]) || o > longint'(box_hi[ax])) return res;
            end else begin
                t0 = slab_dist(box_lo[ax], o, d);
                t1 = slab_dist(box_hi[ax], o, d);
                if (t1 < t0) begin
                    tmp = t0; t0 = t1; t1 = tmp;
                end
                if (t0 > near_t) near_t = t0;
                if (t1 < far_t) far_t = t1;
                if (far_t < near_t || far_t < 0) return res;
            end
        end
        hit_dist = (near_t > 0) ? near_t : far_t;
        if (r.length_limited && hit_dist > longint'(r.max_length)) return res;
        res.hit = 1'b1;
        res.hit_distance = hit_dist[CW-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        hit_t want;
        if (aresetn && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_hits.size() == 0) begin
                $error("unexpected result hit=%0d hit_distance=%h", m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = pending_hits.pop_front();
                if (m_axis_tuser[0] !== want.hit) begin
                    $error("hit: expected %0d actual %0d", want.hit, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata !== want.hit_distance) begin
                    $error("hit_distance: expected %h actual %h",
                           want.hit_distance, m_axis_tdata);
                    errors++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int p;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(1, 4);
        return $urandom_range(10, 80);
    endfunction

    // drive sink backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end else if (($urandom_range(99) < 25) && !calm) begin
            sink_stall <= pick_gap();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(rasl_cfg_idx_t idx, logic [CW-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BOX_MIN_X: box_lo[0] = value;
            CFG_BOX_MIN_Y: box_lo[1] = value;
            CFG_BOX_MIN_Z: box_lo[2] = value;
            CFG_BOX_MAX_X: box_hi[0] = value;
            CFG_BOX_MAX_Y: box_hi[1] = value;
            CFG_BOX_MAX_Z: box_hi[2] = value;
            default:       par_thr = value[THR_WIDTH-1:0];
        endcase
    endtask

    task automatic idle_input();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        idle_input();
        while (pending_hits.size() != 0) @(posedge aclk);
        repeat (LATENCY + 6) @(posedge aclk);
    endtask

    task automatic load_box(logic [CW-1:0] lx, logic [CW-1:0] ly, logic [CW-1:0] lz,
                            logic [CW-1:0] hx, logic [CW-1:0] hy, logic [CW-1:0] hz,
                            logic [CW-1:0] thr);
        drain();
        write_reg(CFG_BOX_MIN_X, lx);
        write_reg(CFG_BOX_MIN_Y, ly);
        write_reg(CFG_BOX_MIN_Z, lz);
        write_reg(CFG_BOX_MAX_X, hx);
        write_reg(CFG_BOX_MAX_Y, hy);
        write_reg(CFG_BOX_MAX_Z, hz);
        write_reg(CFG_PAR_THR, thr);
    endtask

    task automatic send_ray(ray_t r, bit gaps = 1'b1);
        int gap;
        gap = gaps ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {r.max_length, r.dir[2], r.dir[1], r.dir[0],
                         r.origin[2], r.origin[1], r.origin[0]};
        s_axis_tuser <= r.length_limited;
        do @(posedge aclk); while (!s_axis_tready);
        pending_hits.push_back(trace_ray(r));
    endtask

    function automatic ray_t make_ray(logic [CW-1:0] ox, logic [CW-1:0] oy, logic [CW-1:0] oz,
                                      logic [CW-1:0] dx, logic [CW-1:0] dy, logic [CW-1:0] dz,
                                      logic [CW-1:0] ml, logic lim);
        ray_t r;
        r.origin[0] = ox; r.origin[1] = oy; r.origin[2] = oz;
        r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
        r.max_length = ml;
        r.length_limited = lim;
        return r;
    endfunction

    function automatic logic [CW-1:0] rnd_word();
        int p;
        p = $urandom_range(9);
        if (p == 0) return 32'h8000_0000;
        if (p == 1) return 32'h7fff_ffff;
        if (p < 4) return $urandom_range(0, 8) - 4;
        return $urandom;
    endfunction

    function automatic ray_t aimed_ray();
        ray_t r;
        int   t;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            t = $urandom_range(99);
            r.origin[ax] = box_lo[ax] - $signed(32'($urandom_range(0, 32'h000f_ffff)));
            if (t < 40)
                r.origin[ax] = box_lo[ax] + ((box_hi[ax] - box_lo[ax]) >>> 1);
            else if (t < 60)
                r.origin[ax] = box_hi[ax] + $signed(32'($urandom_range(0, 32'h000f_ffff)));
            t = $urandom_range(99);
            if (t < 10)
                r.dir[ax] = '0;
            else if (t < 20)
                r.dir[ax] = $signed(32'(par_thr)) + $signed(32'($urandom_range(0, 2))) - 1;
            else if (t < 25)
                r.dir[ax] = $urandom;
            else
                r.dir[ax] = $signed(32'($urandom_range(1, 32'h0003_ffff)));
            if (r.origin[ax] > box_hi[ax] && $urandom_range(1)) r.dir[ax] = -r.dir[ax];
            if (t >= 25 && $urandom_range(9) == 0) r.dir[ax] = -r.dir[ax];
        end
        r.max_length = $urandom_range(3) == 0 ? rnd_word()
                                               : 32'($urandom_range(0, 32'h0040_0000));
        r.length_limited = $urandom_range(1);
        return r;
    endfunction

    function automatic ray_t noise_ray();
        return make_ray(rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                        rnd_word(), $urandom_range(1));
    endfunction

    task automatic test_reset_box();
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            box_lo[ax] = '0;
            box_hi[ax] = '0;
        end
        par_thr = THR_RESET;
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(1, 0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(-32'sd65536, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
    endtask

    task automatic test_directed();
        load_box(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000,
                 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0100);
        // hit from outside, from inside, behind the ray
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, 0, 32'h0001_0000, 32'h0000_8000, 0, 0, 0));
        send_ray(make_ray(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0, 0, 0));
        // parallel axis inside and outside the slab, just below and at threshold
        send_ray(make_ray(-32'sh0005_0000, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 0, 0));
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 32'h0000_00ff, 0, 0, 0));
        send_ray(make_ray(-32'sh0005_0000, 32'h0001_0000, 0, 32'h0001_0000, 32'h0000_0100,
                          0, 0, 0));
        // diagonal ray entering at a corner
        send_ray(make_ray(-32'sh0002_0000, -32'sh0002_0000, 0, 32'h0001_0000, 32'h0001_0000,
                          0, 0, 0));
        // length limit at and below the distance, and a ray with the limit off
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0004_0000, 1));
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h0003_ffff, 1));
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 0, 0, 32'h8000_0000, 0));
        // saturating quotients with minimal direction and extreme origin
        send_ray(make_ray(32'h8000_0000, 0, 0, 32'h0000_0100, 0, 0, 32'h7fff_ffff, 1));
        send_ray(make_ray(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
        send_ray(make_ray(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1));
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0000);
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0));
        send_ray(make_ray(0, 0, 0, 1, 1, 32'hffff_ffff, 0, 0));
        send_ray(make_ray(32'h8000_0000, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 0, 0, 1));
        // inverted box
        load_box(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000, 32'hffff_0000,
                 32'hffff_0000, 32'h0000_ffff);
        send_ray(make_ray(0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0));
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          0, 0));
        send_ray(make_ray(-32'sh0005_0000, 0, 0, 32'h0001_0000, 32'h0000_fffe,
                          32'h0001_0000, 0, 0));
    endtask

    task automatic run_random(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 80) send_ray(aimed_ray(), i % 100 >= 20);
            else send_ray(noise_ray(), i % 100 >= 20);
        end
        idle_input();
    endtask

    task automatic random_box();
        logic signed [CW-1:0] lo[3], hi[3];
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            lo[ax] = $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
            hi[ax] = lo[ax] + $signed(32'($urandom_range(0, 32'h0008_0000)));
            if ($urandom_range(15) == 0) hi[ax] = lo[ax] - 1;
        end
        load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 16'hffff));
    endtask

    task automatic test_random_boxes();
        for (int k = 0; k < 8; k++) begin
            random_box();
            run_random(95);
        end
    endtask

    task automatic test_extreme_boxes();
        load_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_ffff);
        run_random(120);
        load_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000);
        run_random(80);
        load_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 16'h0001);
        run_random(80);
    endtask

    task automatic test_back_to_back();
        random_box();
        calm = 1'b1;
        for (int i = 0; i < 150; i++) send_ray(aimed_ray(), 1'b0);
        idle_input();
        calm = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_box();
        test_directed();
        test_random_boxes();
        test_extreme_boxes();
        test_back_to_back();
        drain();
        if (errors == 0 && pending_hits.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
